/* rtl/core/ppc_pkg.sv */
// Shared types, constants and helper functions for the planar pose composer.
`default_nettype none

package ppc_pkg;

  // Field widths fixed by the item format
  localparam int COORD_W        = 32;
  localparam int ANGLE_W        = 16;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 32;

  // Default heading resolution in bits per full turn
  localparam int ANGLE_BITS_DEF = 16;

  // Trig values are Q1.16, carried as 18-bit signed
  localparam int TRIG_MAG_W     = 17;
  localparam int TRIG_W         = 18;
  localparam int TRIG_FRAC      = 16;

  // Register map of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROOT_X     = 4'd0,
    REG_ROOT_Y     = 4'd1,
    REG_ROOT_Z     = 4'd2,
    REG_ROOT_ANGLE = 4'd3
  } cfg_reg_t;

  // Quarter-wave sine, entry k = round(65536 * sin(k * quarter / 16))
  localparam logic [TRIG_MAG_W-1:0] SIN_TAB [17] = '{
    17'd0,     17'd6424,  17'd12785, 17'd19024, 17'd25080, 17'd30893,
    17'd36410, 17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798,
    17'd60547, 17'd62714, 17'd64277, 17'd65220, 17'd65536
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x;
    logic signed [COORD_W-1:0] local_y;
    logic signed [COORD_W-1:0] local_z;
    logic        [ANGLE_W-1:0] local_angle;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] world_z;
    logic        [ANGLE_W-1:0] world_angle;
    logic                      saturated;
  } out_t;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // True when a widened sum falls outside the 32-bit signed range
  function automatic logic sat_over(input logic signed [35:0] v);
    return (v > 36'sd2147483647) || (v < -36'sd2147483648);
  endfunction

  // Clamp a widened sum into the 32-bit signed range
  function automatic logic signed [COORD_W-1:0] sat_clamp(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return COORD_MAX;
    end else if (v < -36'sd2147483648) begin
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/planar_pose_compose.sv */
// An input transaction moves through the stage 1, 2 and 3 registers to the output.
// Throughput: one transaction per cycle; the four stages (trig lookup, multiply,
//   rotate and round, offset and clamp) all advance together on a single enable.
// Backpressure stalls every stage at once; the output register holds its result.
// Reset (rst, synchronous, active high) clears all stage valid bits and sets the
//   root pose registers to zero.
`default_nettype none

module planar_pose_compose #(
  parameter int ANGLE_BITS = ppc_pkg::ANGLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  ppc_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ppc_pkg::out_t                        out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [ppc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [ppc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import ppc_pkg::*;

  localparam int QS  = ANGLE_BITS - 2;  // bits of position inside a quadrant
  localparam int SEG = ANGLE_BITS - 6;  // bits of interpolation fraction

  // Sine of a first-quadrant position 0 .. 2^QS, Q1.16
  function automatic logic [TRIG_MAG_W-1:0] quarter_sin(input logic [QS:0] pp);
    logic [4:0]                seg;
    logic [SEG-1:0]            f;
    logic [TRIG_MAG_W-1:0]     lo;
    logic [TRIG_MAG_W-1:0]     hi;
    logic [TRIG_MAG_W+SEG-1:0] prod;
    seg  = pp[QS:SEG];
    f    = pp[SEG-1:0];
    lo   = SIN_TAB[{1'b0, seg[3:0]}];
    hi   = SIN_TAB[{1'b0, seg[3:0]} + 5'd1];
    prod = (TRIG_MAG_W+SEG)'(hi - lo) * (TRIG_MAG_W+SEG)'(f);
    if (seg[4]) begin
      return SIN_TAB[5'd16];
    end
    return lo + prod[TRIG_MAG_W+SEG-1:SEG];
  endfunction

  // Signed sine over the full turn from quadrant and position
  function automatic logic signed [TRIG_W-1:0] fix_trig(input logic [1:0]    quad,
                                                        input logic [QS-1:0] p);
    logic [QS:0]           mirror;
    logic [TRIG_MAG_W-1:0] mag;
    mirror = {1'b1, {QS{1'b0}}} - {1'b0, p};
    mag    = quad[0] ? quarter_sin(mirror) : quarter_sin({1'b0, p});
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Root pose registers
  logic signed [COORD_W-1:0] root_x;
  logic signed [COORD_W-1:0] root_y;
  logic signed [COORD_W-1:0] root_z;
  logic        [ANGLE_W-1:0] root_angle;

  assign cfg_ready = 1'b1;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      root_x     <= '0;
      root_y     <= '0;
      root_z     <= '0;
      root_angle <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROOT_X:     root_x     <= cfg_data;
        REG_ROOT_Y:     root_y     <= cfg_data;
        REG_ROOT_Z:     root_z     <= cfg_data;
        REG_ROOT_ANGLE: root_angle <= cfg_data[ANGLE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Pipeline enable: advance whenever the output register is free or drained
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: angle fit, sine and cosine of the root heading, heading sum
  logic [ANGLE_BITS+ANGLE_W-1:0] ra_wide;
  logic [ANGLE_BITS+ANGLE_W-1:0] la_wide;
  logic [ANGLE_BITS-1:0]         ra;
  logic [ANGLE_BITS-1:0]         angle_sum;
  logic [ANGLE_BITS+ANGLE_W-1:0] angle_wide;
  logic [1:0]                    quad;
  logic signed [TRIG_W-1:0]      sin_val;
  logic signed [TRIG_W-1:0]      cos_val;

  always_comb begin
    ra_wide    = {{ANGLE_BITS{1'b0}}, root_angle};
    la_wide    = {{ANGLE_BITS{1'b0}}, in_data.local_angle};
    ra         = ra_wide[ANGLE_BITS-1:0];
    angle_sum  = ra + la_wide[ANGLE_BITS-1:0];
    angle_wide = {{ANGLE_W{1'b0}}, angle_sum};
    quad       = ra[ANGLE_BITS-1:ANGLE_BITS-2];
    sin_val    = fix_trig(quad, ra[QS-1:0]);
    cos_val    = fix_trig(quad + 2'd1, ra[QS-1:0]);
  end

  logic                      v1;
  logic signed [COORD_W-1:0] s1_lx;
  logic signed [COORD_W-1:0] s1_ly;
  logic signed [COORD_W-1:0] s1_lz;
  logic signed [TRIG_W-1:0]  s1_sin;
  logic signed [TRIG_W-1:0]  s1_cos;
  logic        [ANGLE_W-1:0] s1_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lx    <= in_data.local_x;
      s1_ly    <= in_data.local_y;
      s1_lz    <= in_data.local_z;
      s1_sin   <= sin_val;
      s1_cos   <= cos_val;
      s1_angle <= angle_wide[ANGLE_W-1:0];
    end
  end

  // Stage 2: four 32x18 products of the rotation
  logic                      v2;
  logic signed [49:0]        p_xc;
  logic signed [49:0]        p_ys;
  logic signed [49:0]        p_yc;
  logic signed [49:0]        p_xs;
  logic signed [COORD_W-1:0] s2_lz;
  logic        [ANGLE_W-1:0] s2_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xc     <= 50'(s1_lx) * 50'(s1_cos);
      p_ys     <= 50'(s1_ly) * 50'(s1_sin);
      p_yc     <= 50'(s1_ly) * 50'(s1_cos);
      p_xs     <= 50'(s1_lx) * 50'(s1_sin);
      s2_lz    <= s1_lz;
      s2_angle <= s1_angle;
    end
  end

  // Stage 3: combine products, round Q.32 to Q.16 (ties up), add Z
  logic signed [50:0] sum_x;
  logic signed [50:0] sum_y;
  logic signed [32:0] z_sum;

  always_comb begin
    sum_x = 51'(p_xc) - 51'(p_ys) + 51'sd32768;
    sum_y = 51'(p_yc) + 51'(p_xs) + 51'sd32768;
    z_sum = 33'(s2_lz) + 33'(root_z);
  end

  logic                      v3;
  logic signed [34:0]        s3_rx;
  logic signed [34:0]        s3_ry;
  logic signed [32:0]        s3_z;
  logic        [ANGLE_W-1:0] s3_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rx    <= sum_x[50:TRIG_FRAC];
      s3_ry    <= sum_y[50:TRIG_FRAC];
      s3_z     <= z_sum;
      s3_angle <= s2_angle;
    end
  end

  // Stage 4: add root X and Y, clamp, load output register
  logic signed [35:0] wx;
  logic signed [35:0] wy;
  logic signed [35:0] wz;
  out_t               result;

  always_comb begin
    wx                 = 36'(s3_rx) + 36'(root_x);
    wy                 = 36'(s3_ry) + 36'(root_y);
    wz                 = 36'(s3_z);
    result.world_x     = sat_clamp(wx);
    result.world_y     = sat_clamp(wy);
    result.world_z     = sat_clamp(wz);
    result.world_angle = s3_angle;
    result.saturated   = sat_over(wx) || sat_over(wy) || sat_over(wz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ppc_checker.sv */
// Port-level assertions for the planar pose composer, bound to the top level.
`default_nettype none

module ppc_checker (
  input wire           clk,
  input wire           rst,
  input wire           in_valid,
  input wire           in_ready,
  input wire           out_valid,
  input wire           out_ready,
  input ppc_pkg::out_t out_data
);

  import ppc_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Never refuse input while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused with empty output register");

  // A transaction reaches the output through stages 1 to 3 when nothing stalls it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing four cycles after input transaction");

  // A clamp flag implies some coordinate sits at a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.world_x == COORD_MAX) || (out_data.world_x == COORD_MIN) ||
      (out_data.world_y == COORD_MAX) || (out_data.world_y == COORD_MIN) ||
      (out_data.world_z == COORD_MAX) || (out_data.world_z == COORD_MIN))
    else $error("saturated flag set with no coordinate at a bound");

endmodule

bind planar_pose_compose ppc_checker u_ppc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/pose_check_pkg.sv */
// Scoreboard for the planar pose composer: root registers, pose prediction, result checks.
`timescale 1ns / 100ps

package pose_check_pkg;

  import ppc_pkg::*;

  // Angle format: 16 bits per full turn, quarter wave in 16 segments
  localparam int unsigned TURN_MASK    = 32'h0000_FFFF;
  localparam int unsigned QUARTER_TURN = 32'h0000_4000;
  localparam int unsigned QUARTER_BITS = 14;
  localparam int unsigned SEGMENT_BITS = 10;
  localparam int unsigned PRODUCT_FRAC = 16;
  localparam longint      HALF_LSB     = 64'sd32768;
  localparam longint      COORD_HI     = 64'sd2147483647;
  localparam longint      COORD_LO     = -64'sd2147483648;

  // Quarter-wave sine points in Q1.16
  localparam int QUARTER_WAVE [17] = '{
    0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
    50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536
  };

  class pose_scoreboard;
    logic signed [COORD_W-1:0] root_x;
    logic signed [COORD_W-1:0] root_y;
    logic signed [COORD_W-1:0] root_z;
    logic        [ANGLE_W-1:0] root_angle;
    out_t                      pending_poses[$];
    int unsigned               mismatches;
    int unsigned               poses_in;
    int unsigned               poses_out;
    int unsigned               clamped_out;

    function new();
      root_x      = '0;
      root_y      = '0;
      root_z      = '0;
      root_angle  = '0;
      mismatches  = 0;
      poses_in    = 0;
      poses_out   = 0;
      clamped_out = 0;
    endfunction

    // Apply a register write; indexes past the map change nothing
    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_ROOT_X:     root_x = data;
        REG_ROOT_Y:     root_y = data;
        REG_ROOT_Z:     root_z = data;
        REG_ROOT_ANGLE: root_angle = data[ANGLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Interpolate sine within the first quadrant, p from 0 to a full quarter
    function longint first_quadrant_sin(int unsigned p);
      int unsigned seg;
      int unsigned frac;
      longint      step;
      seg  = p >> SEGMENT_BITS;
      frac = p & ((1 << SEGMENT_BITS) - 1);
      if (seg >= 16) begin
        return QUARTER_WAVE[16];
      end
      step = QUARTER_WAVE[seg + 1] - QUARTER_WAVE[seg];
      return QUARTER_WAVE[seg] + ((step * frac) >>> SEGMENT_BITS);
    endfunction

    // Fold a full-turn angle onto the first quadrant
    function longint turn_sin(int unsigned angle);
      int unsigned full;
      int unsigned p;
      full = angle & TURN_MASK;
      p    = full & (QUARTER_TURN - 1);
      case (full >> QUARTER_BITS)
        0:       return first_quadrant_sin(p);
        1:       return first_quadrant_sin(QUARTER_TURN - p);
        2:       return -first_quadrant_sin(p);
        default: return -first_quadrant_sin(QUARTER_TURN - p);
      endcase
    endfunction

    function logic signed [COORD_W-1:0] clamp_coord(input longint v, inout bit clipped);
      if (v > COORD_HI) begin
        clipped = 1'b1;
        return COORD_HI[COORD_W-1:0];
      end else if (v < COORD_LO) begin
        clipped = 1'b1;
        return COORD_LO[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
    endfunction

    // Rotate the offset by the root heading, round to Q.16, add the root, clamp
    function void note_input(in_t item);
      longint lx;
      longint ly;
      longint lz;
      longint sn;
      longint cs;
      longint rot_x;
      longint rot_y;
      longint base;
      bit     clipped;
      out_t   pose;
      lx      = item.local_x;
      ly      = item.local_y;
      lz      = item.local_z;
      sn      = turn_sin(int'(root_angle));
      cs      = turn_sin(int'(root_angle) + QUARTER_TURN);
      rot_x   = (lx * cs - ly * sn + HALF_LSB) >>> PRODUCT_FRAC;
      rot_y   = (ly * cs + lx * sn + HALF_LSB) >>> PRODUCT_FRAC;
      clipped = 1'b0;
      base    = root_x;
      pose.world_x = clamp_coord(base + rot_x, clipped);
      base    = root_y;
      pose.world_y = clamp_coord(base + rot_y, clipped);
      base    = root_z;
      pose.world_z = clamp_coord(base + lz, clipped);
      pose.world_angle = root_angle + item.local_angle;
      pose.saturated   = clipped;
      pending_poses.insert(pending_poses.size(), pose);
      poses_in++;
    endfunction

    // Compare a result transaction against the oldest predicted pose
    function void check_result(out_t got);
      out_t want;
      if (pending_poses.size() == 0) begin
        $error("result with no pose outstanding: x %0d y %0d z %0d", got.world_x,
               got.world_y, got.world_z);
        mismatches++;
        return;
      end
      want = pending_poses.pop_front();
      poses_out++;
      if (got.saturated === 1'b1) begin
        clamped_out++;
      end
      if (got.world_x !== want.world_x) begin
        $error("world_x: expected %0d, got %0d", want.world_x, got.world_x);
        mismatches++;
      end
      if (got.world_y !== want.world_y) begin
        $error("world_y: expected %0d, got %0d", want.world_y, got.world_y);
        mismatches++;
      end
      if (got.world_z !== want.world_z) begin
        $error("world_z: expected %0d, got %0d", want.world_z, got.world_z);
        mismatches++;
      end
      if (got.world_angle !== want.world_angle) begin
        $error("world_angle: expected %0d, got %0d", want.world_angle, got.world_angle);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// Top-level testbench for planar_pose_compose: stimulus, flow control and final verdict.
`timescale 1ns / 100ps

module tb;

  import ppc_pkg::*;
  import pose_check_pkg::*;

  localparam int LATENCY        = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF       = 300;
  localparam int BURST_ITEMS    = 40;
  localparam int BLOCK_ITEMS    = 22;
  localparam int BLOCKS         = 4;

  localparam logic signed [COORD_W-1:0] POS_EDGE = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] NEG_EDGE = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] ONE      = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] HALF     = 32'sh0000_8000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_t                   out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pose_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_cycles;
  int unsigned    quiet_cycles;
  int unsigned    root_settings;

  planar_pose_compose dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive the result side: long hold-off first, else random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Record every transaction on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
    end
  end

  // Abort when no channel has moved a transaction for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no transaction in %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_t make_pose(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                    logic signed [COORD_W-1:0] z, logic [ANGLE_W-1:0] a);
    in_t p;
    p.local_x     = x;
    p.local_y     = y;
    p.local_z     = z;
    p.local_angle = a;
    return p;
  endfunction

  // Mix range edges, small offsets and full-range values
  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       v = POS_EDGE;
          1:       v = NEG_EDGE;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    logic [ANGLE_W-1:0] a;
    case ($urandom_range(3))
      0:       a = 16'($urandom_range(3)) << QUARTER_BITS;
      1:       a = 16'hFFFF - 16'($urandom_range(3));
      default: a = 16'($urandom());
    endcase
    return a;
  endfunction

  // Hold valid and payload until the pose is taken; call at a falling edge
  task automatic send_pose(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load a new root pose; junk in the upper angle bits must be dropped
  task automatic set_root(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                          input logic signed [COORD_W-1:0] z, input logic [ANGLE_W-1:0] a);
    write_cfg(REG_ROOT_X, x);
    write_cfg(REG_ROOT_Y, y);
    write_cfg(REG_ROOT_Z, z);
    write_cfg(REG_ROOT_ANGLE, {16'($urandom()), a});
    root_settings++;
  endtask

  // Stop offering poses until the pipeline has drained
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_poses.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    logic [ANGLE_W-1:0] turn_points [5];
    sb             = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    root_settings  = 0;
    turn_points    = '{16'h4000, 16'h8000, 16'hC000, 16'h03FF, 16'h0400};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Root at reset value: zero, all-ones and range edges
    send_pose(make_pose('0, '0, '0, '0));
    send_pose(make_pose(POS_EDGE, POS_EDGE, POS_EDGE, 16'hFFFF));
    send_pose(make_pose(NEG_EDGE, NEG_EDGE, NEG_EDGE, '0));
    send_pose(make_pose(-1, 1, -1, 16'h8000));
    wait_drained();

    // Clamp high on x and z, low on y, with heading wrap
    set_root(POS_EDGE, NEG_EDGE, POS_EDGE, 16'hFFFF);
    send_pose(make_pose(ONE, -ONE, ONE, 16'h0001));
    send_pose(make_pose(NEG_EDGE, POS_EDGE, NEG_EDGE, 16'hFFFF));
    wait_drained();

    // Clamp low on x and z, high on y
    set_root(NEG_EDGE, POS_EDGE, NEG_EDGE, '0);
    send_pose(make_pose(-ONE, ONE, -1, '0));
    wait_drained();

    // Exact half-LSB ties at an eighth of a turn, both signs
    set_root('0, '0, '0, 16'h2000);
    send_pose(make_pose(HALF, '0, '0, '0));
    send_pose(make_pose(-HALF, '0, '0, '0));
    send_pose(make_pose('0, HALF, '0, '0));
    wait_drained();

    // Quadrant corners and a segment boundary of the sine table
    foreach (turn_points[k]) begin
      set_root(rand_coord(), rand_coord(), rand_coord(), turn_points[k]);
      send_pose(make_pose(rand_coord(), rand_coord(), rand_coord(), rand_angle()));
      wait_drained();
    end

    // Write past the register map; the root pose must stay as it is
    write_cfg(CFG_INDEX_W'(int'(REG_ROOT_ANGLE) + 1 +
                           $urandom_range(CFG_INDEX_W * 3 - 2 - 1)), $urandom());
    write_cfg(CFG_INDEX_W'((1 << CFG_INDEX_W) - 1), $urandom());
    send_pose(make_pose(ONE, ONE, ONE, 16'h1234));
    wait_drained();

    // Hold off the result side so the pipeline fills and stalls its input
    set_root(rand_coord(), rand_coord(), rand_coord(), rand_angle());
    hold_cycles = HOLD_OFF;
    repeat (BURST_ITEMS) send_pose(make_pose(rand_coord(), rand_coord(), rand_coord(),
                                             rand_angle()));
    wait_drained();

    // Random poses under four flow-control mixes, new root pose per block
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        wait_drained();
        set_root(rand_coord(), rand_coord(), rand_coord(), rand_angle());
        repeat (BLOCK_ITEMS) send_pose(make_pose(rand_coord(), rand_coord(), rand_coord(),
                                                 rand_angle()));
      end
    end

    // Drain, then give stray results a chance to show up
    in_valid = 1'b0;
    while (sb.pending_poses.size() != 0) @(negedge clk);
    repeat (LATENCY * 4) @(negedge clk);
    if (sb.pending_poses.size() != 0) begin
      $error("%0d predicted poses never arrived", sb.pending_poses.size());
      sb.mismatches++;
    end

    $display("Composed %0d member poses against %0d root poses, %0d results clamped,",
             sb.poses_in, root_settings, sb.clamped_out);
    $display("under steady, sender-idle, receiver-stall, mixed and hold-off traffic.");
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
